// ----- hw/rtl/packed_nibble_to_tile_planar_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the packed nibble to tile planar unit
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef PACKED_NIBBLE_TO_TILE_PLANAR_UNIT_MACROS_SVH
`define PACKED_NIBBLE_TO_TILE_PLANAR_UNIT_MACROS_SVH

// Same-cycle implication.
`define PNTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PNTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pntp_pkg.sv -----
// ---------------------------------------------------------------------------
// Packed nibble to tile planar package
// Frame geometry, payload structs and the queue entry shared by all modules.
// ---------------------------------------------------------------------------
package pntp_pkg;

    localparam int TILES_ACROSS   = 32;
    localparam int TILES_DOWN     = 24;
    localparam int LINES_PER_TILE = 8;
    localparam int TILE_BYTES     = 32;
    localparam int PLANES         = 4;
    localparam int FRAME_LINES    = TILES_DOWN * LINES_PER_TILE;

    localparam int WORD_W = 32;
    localparam int PLANE_W = 8;
    localparam int OFF_W = 15;
    localparam int SUB_W = $clog2(LINES_PER_TILE);
    localparam int COL_W = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int ROW_W = (TILES_DOWN > 1) ? $clog2(TILES_DOWN) : 1;
    localparam int LINE_W = ROW_W + SUB_W;
    localparam int TILE_SHIFT = $clog2(TILE_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Offset of the last tile row in the frame, modulo the offset width.
    localparam int LAST_OFFSET_INT = ((TILES_DOWN - 1) * TILES_ACROSS + TILES_ACROSS - 1)
                                   * TILE_BYTES + (LINES_PER_TILE - 1) * 2;
    localparam logic [OFF_W-1:0] LAST_OFFSET = LAST_OFFSET_INT[OFF_W-1:0];

    typedef struct packed {
        logic [WORD_W-1:0] source_word;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane_zero;
        logic [PLANE_W-1:0] plane_one;
        logic [PLANE_W-1:0] plane_two;
        logic [PLANE_W-1:0] plane_three;
        logic [OFF_W-1:0]   dest_offset;
        logic               last_in_frame;
    } out_item_t;

    // One classified word: pixels plus its place in the staging store.
    typedef struct packed {
        logic [WORD_W-1:0] source_word;
        logic [ROW_W-1:0]  tile_row;
        logic [COL_W-1:0]  column_group;
        logic [SUB_W-1:0]  sub_line;
        logic              last_in_frame;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ----- hw/rtl/pntp_front.sv -----
// ---------------------------------------------------------------------------
// Packed nibble to tile planar front end
// Accepts source words, tracks column group and line, and tags each word.
// ---------------------------------------------------------------------------
module pntp_front
    import pntp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          source_valid,
    output logic          source_ready,
    input  in_item_t      source_item,
    input  queue_status_t queue_status,
    output push_t         push
);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [COL_W-1:0]  col_eff;
    logic [LINE_W-1:0] line_eff;
    logic              col_wrap;
    logic              line_wrap;
    logic              accept;

    assign source_ready = !queue_status.full;
    assign accept = source_valid && source_ready;

    // Frame start clears the position before this word uses it.
    assign col_eff  = source_item.frame_start ? '0 : col_reg;
    assign line_eff = source_item.frame_start ? '0 : line_reg;

    assign col_wrap  = (col_eff == COL_W'(TILES_ACROSS - 1));
    assign line_wrap = (line_eff == LINE_W'(FRAME_LINES - 1));

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (accept)
        begin
            col_next  = col_wrap ? '0 : col_eff + COL_W'(1);
            line_next = line_eff;
            if (col_wrap)
            begin
                line_next = line_wrap ? '0 : line_eff + LINE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    assign push.valid              = accept;
    assign push.entry.source_word  = source_item.source_word;
    assign push.entry.tile_row     = line_eff[LINE_W-1:SUB_W];
    assign push.entry.column_group = col_eff;
    assign push.entry.sub_line     = line_eff[SUB_W-1:0];
    assign push.entry.last_in_frame = col_wrap && line_wrap;

endmodule

// ----- hw/rtl/pntp_queue.sv -----
// ---------------------------------------------------------------------------
// Packed nibble to tile planar queue
// Short FIFO of classified words between the front end and the back end.
// ---------------------------------------------------------------------------
module pntp_queue
    import pntp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_pop = pop && !status.empty;
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ----- hw/rtl/pntp_back.sv -----
// ---------------------------------------------------------------------------
// Packed nibble to tile planar back end
// Splits each word into four bitplanes, forms the staging offset, and holds
// the result in an output register.
// ---------------------------------------------------------------------------
module pntp_back
    import pntp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  entry_t        head,
    input  queue_status_t queue_status,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_ready,
    output out_item_t     result_item
);

    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_item_t               out_reg;
    logic [PLANE_W-1:0]      planes [PLANES];
    logic [OFF_W-1:0]        tile_index;
    logic [OFF_W-1:0]        offset;

    assign pop = !queue_status.empty && (!out_valid_reg || result_ready);

    // Pixel px sits at bits 31-4*px down to 28-4*px; leftmost pixel to bit 7.
    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            for (int px = 0; px < PLANE_W; px++)
            begin
                planes[p][PLANE_W-1-px] = head.source_word[WORD_W-4-4*px+p];
            end
        end
    end

    assign tile_index = OFF_W'(OFF_W'(head.tile_row) * OFF_W'(TILES_ACROSS))
                      + OFF_W'(head.column_group);
    assign offset = OFF_W'(tile_index << TILE_SHIFT) + OFF_W'({head.sub_line, 1'b0});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.plane_zero    <= planes[0];
            out_reg.plane_one     <= planes[1];
            out_reg.plane_two     <= planes[2];
            out_reg.plane_three   <= planes[3];
            out_reg.dest_offset   <= offset;
            out_reg.last_in_frame <= head.last_in_frame;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

// ----- hw/rtl/packed_nibble_to_tile_planar_unit.sv -----
// ---------------------------------------------------------------------------
// Packed nibble to tile planar unit
// Chunky 4bpp to planar tile-row converter with staging offsets.
// ---------------------------------------------------------------------------
// Usage:
//   Source channel (source_valid/source_ready/source_item) takes one 32-bit
//   word of eight 4-bit pixels per handshake; frame_start on a word clears the
//   column group and line counters before that word is placed.
//   Result channel (result_valid/result_ready/result_item) gives one word per
//   source word: four bitplanes, the staging byte offset of plane zero, and
//   a flag on the last word of the frame. Words past the end of a frame wrap
//   to the frame start.
//   Path: an accepted source word is written into the queue, and is loaded
//   into the output register once that register is free or being emptied.
//   Throughput: one word per cycle while the receiver takes results, with the
//   two-entry queue between the front end and the output register of the back end.
//   Reset: counters go to zero, the queue empties, result_valid drops.
//   Receiver stall: the output register holds its word, the queue absorbs
//   up to two more, then source_ready drops until the receiver takes one.
// ---------------------------------------------------------------------------
`include "packed_nibble_to_tile_planar_unit_macros.svh"

module packed_nibble_to_tile_planar_unit
    import pntp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      source_valid,
    output logic      source_ready,
    input  in_item_t  source_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    push_t         push;
    logic          pop;
    entry_t        head;
    queue_status_t queue_status;
    logic          word_taken;
    logic          word_held;
    logic          last_out;
    logic          last_offset_ok;

    pntp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_ready (source_ready),
        .source_item  (source_item),
        .queue_status (queue_status),
        .push         (push)
    );

    pntp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (queue_status)
    );

    pntp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_status (queue_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    assign word_taken     = source_valid && source_ready;
    assign word_held      = !queue_status.empty || result_valid;
    assign last_out       = result_valid && result_item.last_in_frame;
    assign last_offset_ok = (result_item.dest_offset == LAST_OFFSET);

    `PNTP_ASSERT_NOW(a_full_means_stalled, queue_status.full, result_valid, "full while idle")
    `PNTP_ASSERT_NEXT(a_accept_reaches_back, word_taken, word_held, "accepted word lost")
    `PNTP_ASSERT_NOW(a_last_offset, last_out, last_offset_ok, "last word has wrong offset")

endmodule

// ----- tb/packed_nibble_to_tile_planar_unit_tb.sv -----
// ---------------------------------------------------------------------------
// Packed nibble to tile planar unit testbench
// Drives 4bpp source words through the valid/ready source channel and checks
// every result word (four bitplanes, staging offset, end-of-frame flag)
// against an in-bench model of the converter or hand-written expected values.
// A short table of hand-picked words comes first, then random traffic with
// occasional frame starts. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module packed_nibble_to_tile_planar_unit_tb;
    import pntp_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int TABLE_ROWS    = 18;
    localparam int RANDOM_WORDS  = 1950;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              frame_start;
        logic              typed;
        out_item_t         want;
    } table_row_t;

    logic      clk;
    logic      rst_n;
    logic      source_valid;
    logic      source_ready;
    in_item_t  source_item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result_item;

    // model state
    int col_grp;
    int line_idx;

    out_item_t  tile_rows_due[$];
    table_row_t word_table[TABLE_ROWS];
    int         mismatches;
    int         results_seen;
    int         words_sent;
    int         frames_closed;
    int         cycles;
    bit         idle_on;

    packed_nibble_to_tile_planar_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_ready (source_ready),
        .source_item  (source_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycles,
                     tile_rows_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic out_item_t predict_tile_row(in_item_t item);
        out_item_t   row;
        logic [3:0]  nib;
        int          ofs;
        if (item.frame_start)
        begin
            col_grp  = 0;
            line_idx = 0;
        end
        if (col_grp >= TILES_ACROSS)
            col_grp = 0;
        if (line_idx >= FRAME_LINES)
            line_idx = 0;
        row = '0;
        for (int px = 0; px < 8; px++)
        begin
            nib = item.source_word[WORD_W-1-4*px -: 4];
            row.plane_zero[7-px]  = nib[0];
            row.plane_one[7-px]   = nib[1];
            row.plane_two[7-px]   = nib[2];
            row.plane_three[7-px] = nib[3];
        end
        ofs = ((line_idx / LINES_PER_TILE) * TILES_ACROSS + col_grp) * TILE_BYTES
            + (line_idx % LINES_PER_TILE) * 2;
        row.dest_offset   = ofs[OFF_W-1:0];
        row.last_in_frame = (col_grp == TILES_ACROSS - 1) && (line_idx == FRAME_LINES - 1);
        // advance to the next word, wrapping past the end of the frame
        col_grp++;
        if (col_grp >= TILES_ACROSS)
        begin
            col_grp = 0;
            line_idx++;
            if (line_idx >= FRAME_LINES)
                line_idx = 0;
        end
        return row;
    endfunction

    // mostly short, now and then long
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    task automatic send_word(in_item_t item, bit typed, out_item_t want);
        out_item_t modeled;
        int        gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            source_valid <= 1'b0;
        end
        @(negedge clk);
        source_valid <= 1'b1;
        source_item  <= item;
        @(posedge clk);
        while (!source_ready)
            @(posedge clk);
        modeled = predict_tile_row(item);
        tile_rows_due.push_back(typed ? want : modeled);
        words_sent++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Mismatch on %s in result %0d: expected 0x%0h, got 0x%0h",
                         name, results_seen, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (tile_rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result %0d arrived with nothing due", results_seen);
            end
            else
            begin
                want = tile_rows_due.pop_front();
                check_field("plane_zero", 32'(result_item.plane_zero),
                            32'(want.plane_zero));
                check_field("plane_one", 32'(result_item.plane_one),
                            32'(want.plane_one));
                check_field("plane_two", 32'(result_item.plane_two),
                            32'(want.plane_two));
                check_field("plane_three", 32'(result_item.plane_three),
                            32'(want.plane_three));
                check_field("dest_offset", 32'(result_item.dest_offset),
                            32'(want.dest_offset));
                check_field("last_in_frame", 32'(result_item.last_in_frame),
                            32'(want.last_in_frame));
                if (want.last_in_frame)
                    frames_closed++;
            end
        end
    end

    // receiver: random stalls while idling is on
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 99) < 20)
            begin
                result_ready <= 1'b0;
                stall_left = idle_length() - 1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        in_item_t item;
        int       pick;
        rst_n        = 1'b0;
        source_valid = 1'b0;
        source_item  = '0;
        idle_on      = 1'b1;
        col_grp      = 0;
        line_idx     = 0;

        word_table[0]  = {32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'd0, 1'b0};
        word_table[1]  = {32'h0000_0000, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 15'd32, 1'b0};
        word_table[2]  = {32'h8888_8888, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 15'd64, 1'b0};
        word_table[3]  = {32'h1111_1111, 1'b0, 1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 15'd96, 1'b0};
        word_table[4]  = {32'h2222_2222, 1'b0, 1'b0, 48'd0};
        word_table[5]  = {32'h4444_4444, 1'b0, 1'b0, 48'd0};
        word_table[6]  = {32'h1234_5678, 1'b0, 1'b0, 48'd0};
        word_table[7]  = {32'hFEDC_BA98, 1'b0, 1'b0, 48'd0};
        word_table[8]  = {32'hF0F0_F0F0, 1'b0, 1'b0, 48'd0};
        word_table[9]  = {32'h0F0F_0F0F, 1'b0, 1'b0, 48'd0};
        word_table[10] = {32'hA5A5_A5A5, 1'b0, 1'b0, 48'd0};
        word_table[11] = {32'h5A5A_5A5A, 1'b0, 1'b0, 48'd0};
        word_table[12] = {32'h0000_0000, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 15'd0, 1'b0};
        word_table[13] = {32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'd0, 1'b0};
        word_table[14] = {32'h0123_4567, 1'b0, 1'b0, 48'd0};
        word_table[15] = {32'h89AB_CDEF, 1'b0, 1'b0, 48'd0};
        word_table[16] = {32'hDEAD_BEEF, 1'b0, 1'b0, 48'd0};
        word_table[17] = {32'h8000_0001, 1'b0, 1'b0, 48'd0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            item.source_word = word_table[i].word;
            item.frame_start = word_table[i].frame_start;
            send_word(item, word_table[i].typed, word_table[i].want);
        end

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 128 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 15);
            if (pick == 0)
                item.source_word = '0;
            else if (pick == 1)
                item.source_word = '1;
            else
                item.source_word = $urandom;
            item.frame_start = ($urandom_range(0, 63) == 0);
            send_word(item, 1'b0, '0);
        end

        @(negedge clk);
        source_valid <= 1'b0;
        idle_on = 1'b0;
        while (tile_rows_due.size() != 0)
            @(posedge clk);
        // catch any stray result after the last one due
        repeat (8) @(posedge clk);

        $display("Sent %0d words, checked %0d results, %0d frame ends seen, %0d mismatches",
                 words_sent, results_seen, frames_closed, mismatches);
        $display("Covered table words and random words with random frame starts and stalls");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
